>>> hw/rtl/sbte_pkg.sv
// shared types and constants of the six-bit text encoder
package sbte_pkg;

  localparam int unsigned GROUP_W  = 6;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0]  CHAR_OFFSET  = 7'h3c;
  localparam logic [CAP_W-1:0]   CAP_RESET    = 16'hffff;

  // carried bit count divided by two
  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_TWO  = 2'd1;
  localparam logic [1:0] PHASE_FOUR = 2'd2;

  // one queue entry: the results caused by one input beat
  typedef struct packed {
    logic [GROUP_W-1:0] grp_a;
    logic [GROUP_W-1:0] grp_b;
    logic [1:0]         nchar;
    logic               term;
    logic [COUNT_W-1:0] length;
  } rec_t;

endpackage

>>> hw/rtl/sbte_if.sv
// valid/ready channels for input bytes and output characters
interface sbte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sbte_char_if;
  logic        valid;
  logic        ready;
  logic [6:0]  code_char;
  logic        is_terminator;
  logic [16:0] total_length;
  logic        run_last;

  modport source (output valid, output code_char, output is_terminator,
                  output total_length, output run_last, input ready);
  modport sink (input valid, input code_char, input is_terminator,
                input total_length, input run_last, output ready);
endinterface

>>> hw/rtl/six_bit_text_encoder_top.sv
// top level of the six-bit offset text encoder
//
//   channel   dir  beat payload
//   byte_ch   in   data_byte, final_byte
//   char_ch   out  code_char, is_terminator, total_length, run_last
//   capacity  cfg  capacity_we, capacity_wdata (16 bit)
//
// a byte is accepted whenever the two-entry record queue has room
// each byte yields zero to three result beats, sent one per cycle by the back while char_ch is ready
// sustained byte rate is set by the output port; new bytes enter the queue while earlier results drain
// rst is synchronous; capacity returns to 65535 and all carry state clears
// a stalled char_ch holds the queue; bytes keep coming until it fills
module six_bit_text_encoder_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       capacity_we,
  input  logic [sbte_pkg::CAP_W-1:0] capacity_wdata,
  sbte_byte_if.sink                  byte_ch,
  sbte_char_if.source                char_ch
);

  logic           q_full;
  logic           push;
  sbte_pkg::rec_t push_rec;
  logic           pop;
  logic           head_valid;
  sbte_pkg::rec_t head_rec;

  sbte_front u_front (
    .clk            (clk),
    .rst            (rst),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .byte_ch        (byte_ch),
    .q_full         (q_full),
    .push           (push),
    .rec            (push_rec)
  );

  sbte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  sbte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .char_ch    (char_ch)
  );

endmodule

>>> hw/rtl/sbte_front.sv
// front: accepts bytes, tracks the bit carry and capacity, builds at most one record per beat
module sbte_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          capacity_we,
  input  logic [sbte_pkg::CAP_W-1:0]    capacity_wdata,
  sbte_byte_if.sink                     byte_ch,
  input  logic                          q_full,
  output logic                          push,
  output sbte_pkg::rec_t                rec
);

  logic [sbte_pkg::CAP_W-1:0]   capacity;
  logic [sbte_pkg::GROUP_W-1:0] leftover;
  logic [1:0]                   phase;
  logic [sbte_pkg::COUNT_W-1:0] count;
  logic                         stopped;

  logic [sbte_pkg::GROUP_W-1:0] leftover_next;
  logic [1:0]                   phase_next;
  logic [sbte_pkg::COUNT_W-1:0] count_next;
  logic                         stopped_next;

  logic                         accept;
  logic                         stop_now;
  logic [sbte_pkg::COUNT_W-1:0] cap_ext;
  logic [sbte_pkg::COUNT_W-1:0] cnt_one;
  logic [sbte_pkg::GROUP_W-1:0] made;
  logic [sbte_pkg::GROUP_W-1:0] rest;
  logic [7:0]                   b;

  assign byte_ch.ready = !q_full;
  assign accept        = byte_ch.valid && !q_full;
  assign b             = byte_ch.data_byte;
  assign cap_ext       = {1'b0, capacity};
  assign cnt_one       = count + 17'd1;
  assign stop_now      = stopped || (count >= cap_ext);

  always_comb begin
    unique case (phase)
      sbte_pkg::PHASE_NONE: begin
        made = b[7:2];
        rest = {b[1:0], 4'b0000};
      end
      sbte_pkg::PHASE_TWO: begin
        made = leftover | {2'b00, b[7:4]};
        rest = {b[3:0], 2'b00};
      end
      default: begin
        made = leftover | {4'b0000, b[7:6]};
        rest = b[5:0];
      end
    endcase
  end

  always_comb begin
    leftover_next = leftover;
    phase_next    = phase;
    count_next    = count;
    stopped_next  = stop_now;
    rec           = '0;
    if (!stop_now) begin
      rec.grp_a = made;
      rec.nchar = 2'd1;
      if (phase == sbte_pkg::PHASE_NONE || phase == sbte_pkg::PHASE_TWO) begin
        phase_next    = phase + 2'd1;
        leftover_next = rest;
        count_next    = cnt_one;
      end else begin
        // pair completes; the second char only if a slot is left
        phase_next    = sbte_pkg::PHASE_NONE;
        leftover_next = '0;
        if (cnt_one < cap_ext) begin
          rec.grp_b  = rest;
          rec.nchar  = 2'd2;
          count_next = count + 17'd2;
        end else begin
          count_next = cnt_one;
        end
      end
    end
    if (byte_ch.final_byte) begin
      // flush carried bits, even past capacity
      if (phase_next != sbte_pkg::PHASE_NONE) begin
        if (rec.nchar == 2'd0) begin
          rec.grp_a = leftover_next;
        end else begin
          rec.grp_b = leftover_next;
        end
        rec.nchar  = rec.nchar + 2'd1;
        count_next = count_next + 17'd1;
      end
      rec.term      = 1'b1;
      rec.length    = count_next;
      leftover_next = '0;
      phase_next    = sbte_pkg::PHASE_NONE;
      count_next    = '0;
      stopped_next  = 1'b0;
    end
  end

  assign push = accept && (rec.nchar != 2'd0 || rec.term);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sbte_pkg::CAP_RESET;
      leftover <= '0;
      phase    <= sbte_pkg::PHASE_NONE;
      count    <= '0;
      stopped  <= 1'b0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_wdata;
      end
      if (accept) begin
        leftover <= leftover_next;
        phase    <= phase_next;
        count    <= count_next;
        stopped  <= stopped_next;
      end
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("carry phase out of range");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    push && rec.term |-> rec.length <= 17'h10000)
    else $error("terminator length beyond capacity plus flush");

endmodule

>>> hw/rtl/sbte_queue.sv
// two-entry record queue between front and back
module sbte_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbte_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sbte_pkg::rec_t head_rec
);

  localparam int unsigned PTR_W  = $clog2(sbte_pkg::QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(sbte_pkg::QUEUE_DEPTH + 1);

  sbte_pkg::rec_t          entries [sbte_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [FILL_W-1:0]       fill;
  logic                    do_pop;

  assign full       = (fill == FILL_W'(sbte_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_rec   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(sbte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(sbte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (!push && do_pop) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(sbte_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

endmodule

>>> hw/rtl/sbte_back.sv
// back: walks head record, sends one result beat per ready cycle
module sbte_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  sbte_pkg::rec_t head_rec,
  output logic           pop,
  sbte_char_if.source    char_ch
);

  logic [1:0]                   idx;
  logic [1:0]                   items;
  logic                         last;
  logic                         fire;
  logic [sbte_pkg::GROUP_W-1:0] grp;
  logic                         is_char;

  assign items   = head_rec.nchar + {1'b0, head_rec.term};
  assign last    = (idx == items - 2'd1);
  assign fire    = char_ch.valid && char_ch.ready;
  assign pop     = fire && last;
  assign is_char = (idx < head_rec.nchar);
  assign grp     = (idx == 2'd0) ? head_rec.grp_a : head_rec.grp_b;

  always_comb begin
    char_ch.valid         = head_valid;
    char_ch.run_last      = last;
    char_ch.code_char     = '0;
    char_ch.is_terminator = 1'b0;
    char_ch.total_length  = '0;
    if (is_char) begin
      char_ch.code_char = {1'b0, grp} + sbte_pkg::CHAR_OFFSET;
    end else begin
      char_ch.is_terminator = 1'b1;
      char_ch.total_length  = head_rec.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  a_idx_in_rec: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < items)
    else $error("result index past end of record");

endmodule
